>>> hw/rtl/fdbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framed double-buffer receiver package
// Shared types and codes for the frame parser and its channel interfaces.
// ----------------------------------------------------------------------------
package fdbr_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 11;
    localparam int LEN_W  = 16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    localparam byte_t CH_START    = 8'h3A;
    localparam byte_t CH_ACK_HI   = 8'h48;
    localparam byte_t CH_ACK_LO   = 8'h4C;
    localparam byte_t CH_ACK_DATA = 8'h44;
    localparam byte_t CH_DONE     = 8'h21;
    localparam byte_t CH_BAD      = 8'h3F;

endpackage
`default_nettype wire

>>> hw/rtl/fdbr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel that carries one received serial byte per beat.
// ----------------------------------------------------------------------------
interface fdbr_in_if;
    import fdbr_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fdbr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the reply, buffer write and display
// selection produced for one received byte per beat.
// ----------------------------------------------------------------------------
interface fdbr_out_if;
    import fdbr_pkg::*;

    logic  valid;
    logic  ready;
    logic  reply_valid;
    byte_t reply_byte;
    logic  write_valid;
    logic  write_buffer;
    addr_t write_address;
    byte_t write_data;
    logic  shown_buffer;

    modport source (
        output valid, output reply_valid, output reply_byte, output write_valid,
        output write_buffer, output write_address, output write_data,
        output shown_buffer, input ready
    );
    modport sink (
        input valid, input reply_valid, input reply_byte, input write_valid,
        input write_buffer, input write_address, input write_data,
        input shown_buffer, output ready
    );
endinterface
`default_nettype wire

>>> hw/rtl/framed_double_buffer_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framed double-buffer receiver core
// Parses ':' + 16-bit length + payload + closing byte frames, writes the
// payload to the back buffer and swaps buffers at the end of each frame.
//
//   Channel   Direction   Carries
//   item      in          rx_byte
//   result    out         reply, buffer write, shown_buffer
//
// One beat is accepted per cycle; its result appears in the output register
// in the next cycle. The parser state and the result register update in the
// same cycle, so the only limit is the output register: item.ready is low
// only while a result waits and result.ready is low. Reset puts the parser
// in the header wait with buffer 1 as back buffer and buffer 0 shown.
// ----------------------------------------------------------------------------
module framed_double_buffer_receiver_core #(
    parameter int BYTES_PER_ROW = 30,
    parameter int ROWS_PER_HALF = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    fdbr_in_if.sink      item,
    fdbr_out_if.source   result
);
    import fdbr_pkg::*;

    localparam int FRAME_BYTES = 2 * BYTES_PER_ROW * ROWS_PER_HALF;
    localparam logic [LEN_W:0] FRAME_CMP = (LEN_W + 1)'(FRAME_BYTES);

    phase_t phase_reg, phase_next;
    len_t   bytes_left_reg, bytes_left_next;
    addr_t  write_pointer_reg, write_pointer_next;
    logic   back_buffer_reg, back_buffer_next;
    logic   front_buffer_reg, front_buffer_next;

    logic   out_valid_reg, out_valid_next;
    logic   reply_valid_reg, reply_valid_next;
    byte_t  reply_byte_reg, reply_byte_next;
    logic   write_valid_reg, write_valid_next;
    logic   write_buffer_reg, write_buffer_next;
    addr_t  write_address_reg, write_address_next;
    byte_t  write_data_reg, write_data_next;

    logic   accept;
    len_t   length;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign length     = {bytes_left_reg[LEN_W-1:BYTE_W], item.rx_byte};

    always_comb
    begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        write_pointer_next = write_pointer_reg;
        back_buffer_next   = back_buffer_reg;
        front_buffer_next  = front_buffer_reg;
        reply_valid_next   = 1'b0;
        reply_byte_next    = '0;
        write_valid_next   = 1'b0;
        write_buffer_next  = 1'b0;
        write_address_next = '0;
        write_data_next    = '0;
        unique case (phase_reg)
            PH_START:
            begin
                reply_valid_next = 1'b1;
                if (item.rx_byte == CH_START)
                begin
                    reply_byte_next = CH_ACK_HI;
                    phase_next      = PH_LEN_HI;
                end
                else
                begin
                    reply_byte_next = CH_BAD;
                end
            end
            PH_LEN_HI:
            begin
                bytes_left_next  = {item.rx_byte, {BYTE_W{1'b0}}};
                reply_valid_next = 1'b1;
                reply_byte_next  = CH_ACK_LO;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if ({1'b0, length} > FRAME_CMP)
                begin
                    bytes_left_next = FRAME_CMP[LEN_W-1:0];
                end
                else
                begin
                    bytes_left_next = length;
                end
                reply_valid_next   = 1'b1;
                reply_byte_next    = CH_ACK_DATA;
                phase_next         = PH_DATA;
                write_pointer_next = '0;
            end
            PH_DATA:
            begin
                if (bytes_left_reg != '0)
                begin
                    write_valid_next   = 1'b1;
                    write_buffer_next  = back_buffer_reg;
                    write_address_next = write_pointer_reg;
                    write_data_next    = item.rx_byte;
                    write_pointer_next = write_pointer_reg + addr_t'(1);
                    bytes_left_next    = bytes_left_reg - len_t'(1);
                end
                else
                begin
                    reply_valid_next  = 1'b1;
                    reply_byte_next   = CH_DONE;
                    phase_next        = PH_START;
                    front_buffer_next = back_buffer_reg;
                    back_buffer_next  = !back_buffer_reg;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_START;
            bytes_left_reg    <= '0;
            write_pointer_reg <= '0;
            back_buffer_reg   <= 1'b1;
            front_buffer_reg  <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg         <= phase_next;
                bytes_left_reg    <= bytes_left_next;
                write_pointer_reg <= write_pointer_next;
                back_buffer_reg   <= back_buffer_next;
                front_buffer_reg  <= front_buffer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reply_valid_reg   <= reply_valid_next;
            reply_byte_reg    <= reply_byte_next;
            write_valid_reg   <= write_valid_next;
            write_buffer_reg  <= write_buffer_next;
            write_address_reg <= write_address_next;
            write_data_reg    <= write_data_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.reply_valid   = reply_valid_reg;
    assign result.reply_byte    = reply_byte_reg;
    assign result.write_valid   = write_valid_reg;
    assign result.write_buffer  = write_buffer_reg;
    assign result.write_address = write_address_reg;
    assign result.write_data    = write_data_reg;
    assign result.shown_buffer  = front_buffer_reg;

endmodule
`default_nettype wire
